### src/spl_pkg.sv
// Shared types, codes and constants for the seeded permutation lookup.
package spl_pkg;

  localparam int unsigned MAX_ITEMS = 1024;
  localparam int unsigned IDX_W     = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W     = IDX_W + 1;

  // Twister geometry and constants
  localparam logic [9:0]  TW_N      = 10'd624;
  localparam logic [9:0]  TW_M      = 10'd397;
  localparam logic [9:0]  TW_NM     = 10'd227;
  localparam logic [31:0] TW_MULT   = 32'd1812433253;
  localparam logic [31:0] TW_MATRIX = 32'h9908B0DF;

  // Configuration register indexes
  localparam logic CFG_SEED  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  // Datapath operation codes, one per cycle
  localparam int unsigned OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE       = 5'd0;
  localparam logic [OP_W-1:0] OP_LATCH      = 5'd1;
  localparam logic [OP_W-1:0] OP_SEED_INIT  = 5'd2;
  localparam logic [OP_W-1:0] OP_SEED_MUL   = 5'd3;
  localparam logic [OP_W-1:0] OP_SEED_ADD   = 5'd4;
  localparam logic [OP_W-1:0] OP_POOL_INIT  = 5'd5;
  localparam logic [OP_W-1:0] OP_DRAW       = 5'd6;
  localparam logic [OP_W-1:0] OP_RG_A       = 5'd7;
  localparam logic [OP_W-1:0] OP_RG_B       = 5'd8;
  localparam logic [OP_W-1:0] OP_RG_C       = 5'd9;
  localparam logic [OP_W-1:0] OP_RG_D       = 5'd10;
  localparam logic [OP_W-1:0] OP_TW_RD      = 5'd11;
  localparam logic [OP_W-1:0] OP_TW_TEMP    = 5'd12;
  localparam logic [OP_W-1:0] OP_SWAP_RD    = 5'd13;
  localparam logic [OP_W-1:0] OP_SWAP_RD2   = 5'd14;
  localparam logic [OP_W-1:0] OP_SWAP_WR    = 5'd15;
  localparam logic [OP_W-1:0] OP_BUILD_DONE = 5'd16;
  localparam logic [OP_W-1:0] OP_FWD_DIV    = 5'd17;
  localparam logic [OP_W-1:0] OP_PERM_RD    = 5'd18;
  localparam logic [OP_W-1:0] OP_INV_RD     = 5'd19;
  localparam logic [OP_W-1:0] OP_RES_ZERO   = 5'd20;
  localparam logic [OP_W-1:0] OP_RES_QLOW   = 5'd21;
  localparam logic [OP_W-1:0] OP_RES_REM    = 5'd22;
  localparam logic [OP_W-1:0] OP_RES_PERM   = 5'd23;
  localparam logic [OP_W-1:0] OP_RES_INV    = 5'd24;
  localparam logic [OP_W-1:0] OP_OUT        = 5'd25;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic req_inv;
    logic identity;
    logic n_zero;
    logic q_lt_n;
    logic need_build;
    logic idx_last;
    logic pool_last;
    logic ptr_full;
    logic left_one;
    logic div_done;
  } sts_t;

endpackage

### src/spl_div.sv
// Bit-serial remainder unit: 32-bit dividend modulo an 11-bit divisor.
module spl_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [10:0] divisor,
  output logic        done,
  output logic [9:0]  rem
);
  import spl_pkg::*;

  logic [31:0] dvd_r;
  logic [10:0] dsr_r;
  logic [10:0] rem_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [11:0] trial;
  logic        fits;
  logic [10:0] rem_nxt;

  // Shift in one dividend bit and subtract when it fits
  assign trial   = {rem_r, dvd_r[31]};
  assign fits    = trial >= {1'b0, dsr_r};
  assign rem_nxt = fits ? 11'(trial - {1'b0, dsr_r}) : trial[10:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[30:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r[9:0];

endmodule

### src/spl_dp.sv
// Datapath: config registers, twister, pool/permutation/inverse memories, result.
module spl_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [31:0]       cfg_wdata,
  input  logic              in_req_type,
  input  logic [30:0]       in_query_value,
  input  spl_pkg::cmd_t     cmd,
  output spl_pkg::sts_t     sts,
  output logic [9:0]        out_result_index
);
  import spl_pkg::*;

  logic [31:0] seed_r;
  logic [10:0] count_r;
  logic        valid_r;
  logic [30:0] built_r;
  logic        req_r;
  logic [30:0] q_r;
  logic [9:0]  res_r;
  logic [9:0]  out_r;

  logic [10:0] n;
  logic [9:0]  idx_r;
  logic [9:0]  ptr_r;
  logic [10:0] left_r;
  logic [9:0]  k_r;
  logic [31:0] p_r;
  logic [31:0] prod_r;
  logic [31:0] a_r;
  logic [31:0] b_r;
  logic [9:0]  pick_r;

  logic [31:0] tw_mem [0:623];
  logic [31:0] tw_q_r;
  logic [9:0]  tw_raddr;
  logic        tw_we;
  logic [9:0]  tw_waddr;
  logic [31:0] tw_wdata;

  logic [9:0]  pool_mem [0:MAX_ITEMS-1];
  logic [9:0]  perm_mem [0:MAX_ITEMS-1];
  logic [9:0]  inv_mem  [0:MAX_ITEMS-1];
  logic [9:0]  pool_q_r;
  logic [9:0]  perm_q_r;
  logic [9:0]  inv_q_r;
  logic [9:0]  pool_raddr;
  logic [9:0]  perm_raddr;

  logic [31:0] seed_word;
  logic [31:0] rg_y;
  logic [31:0] rg_word;
  logic [31:0] t1, t2, t3, tempered;
  logic [9:0]  idx_p1;
  logic [9:0]  idx_pm;

  logic        div_start;
  logic [31:0] div_dvd;
  logic [10:0] div_dsr;
  logic        div_done;
  logic [9:0]  div_rem;

  // Saturate the item count to capacity
  assign n = (count_r > 11'(MAX_ITEMS)) ? 11'(MAX_ITEMS) : count_r;

  // Configuration registers; a count write drops the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= 32'hFFFF_FFFF;
      count_r <= '0;
      valid_r <= 1'b0;
      built_r <= '0;
    end else begin
      if (cfg_we && cfg_index[0] == CFG_SEED) seed_r <= cfg_wdata;
      if (cfg_we && cfg_index[0] == CFG_COUNT) begin
        count_r <= cfg_wdata[10:0];
        valid_r <= 1'b0;
      end else if (cmd.op == OP_BUILD_DONE) begin
        valid_r <= 1'b1;
        built_r <= seed_r[30:0];
      end
    end
  end

  // Twister arithmetic
  assign seed_word = prod_r + {22'd0, idx_r};
  assign idx_p1    = (idx_r == TW_N - 10'd1) ? 10'd0 : idx_r + 10'd1;
  assign idx_pm    = (idx_r < TW_NM) ? idx_r + TW_M : idx_r - TW_NM;
  assign rg_y      = {a_r[31], b_r[30:0]};
  assign rg_word   = tw_q_r ^ (rg_y >> 1) ^ (rg_y[0] ? TW_MATRIX : 32'd0);
  assign t1        = tw_q_r ^ (tw_q_r >> 11);
  assign t2        = t1 ^ ((t1 << 7) & 32'h9D2C5680);
  assign t3        = t2 ^ ((t2 << 15) & 32'hEFC60000);
  assign tempered  = t3 ^ (t3 >> 18);

  // Twister memory port selection
  always_comb begin
    tw_raddr = ptr_r;
    tw_we    = 1'b0;
    tw_waddr = idx_r;
    tw_wdata = seed_word;
    case (cmd.op)
      OP_RG_A:      tw_raddr = idx_r;
      OP_RG_B:      tw_raddr = idx_p1;
      OP_RG_C:      tw_raddr = idx_pm;
      OP_SEED_INIT: begin
        tw_we    = 1'b1;
        tw_waddr = '0;
        tw_wdata = seed_r;
      end
      OP_SEED_ADD:  tw_we = 1'b1;
      OP_RG_D: begin
        tw_we    = 1'b1;
        tw_wdata = rg_word;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tw_we) tw_mem[tw_waddr] <= tw_wdata;
    tw_q_r <= tw_mem[tw_raddr];
  end

  // Pool, permutation and inverse memories
  assign pool_raddr = (cmd.op == OP_SWAP_RD2) ? 10'(left_r - 11'd1) : div_rem;
  assign perm_raddr = div_rem;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_POOL_INIT) pool_mem[idx_r] <= idx_r;
    else if (cmd.op == OP_SWAP_WR) pool_mem[div_rem] <= pool_q_r;
    if (cmd.op == OP_SWAP_WR) begin
      perm_mem[k_r]   <= pick_r;
      inv_mem[pick_r] <= k_r;
    end
    pool_q_r <= pool_mem[pool_raddr];
    perm_q_r <= perm_mem[perm_raddr];
    inv_q_r  <= inv_mem[q_r[9:0]];
  end

  // Sequencing counters
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SEED_INIT: begin
        idx_r  <= 10'd1;
        ptr_r  <= TW_N;
        left_r <= n;
        k_r    <= '0;
        p_r    <= seed_r;
      end
      OP_SEED_ADD: begin
        idx_r <= idx_p1;
        p_r   <= seed_word;
      end
      OP_POOL_INIT: idx_r <= idx_r + 10'd1;
      OP_DRAW:      idx_r <= '0;
      OP_RG_D: begin
        idx_r <= idx_p1;
        if (idx_r == TW_N - 10'd1) ptr_r <= '0;
      end
      OP_TW_TEMP:   ptr_r <= ptr_r + 10'd1;
      OP_SWAP_WR: begin
        left_r <= left_r - 11'd1;
        k_r    <= k_r + 10'd1;
      end
      default: ;
    endcase
  end

  // Operand and pick registers
  always_ff @(posedge clk) begin
    if (cmd.op == OP_SEED_MUL) prod_r <= TW_MULT * (p_r ^ (p_r >> 30));
    if (cmd.op == OP_RG_B) a_r <= tw_q_r;
    if (cmd.op == OP_RG_C) b_r <= tw_q_r;
    if (cmd.op == OP_SWAP_RD2) pick_r <= pool_q_r;
    if (cmd.op == OP_LATCH) begin
      req_r <= in_req_type;
      q_r   <= in_query_value;
    end
  end

  // Result and output registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_RES_ZERO: res_r <= '0;
      OP_RES_QLOW: res_r <= q_r[9:0];
      OP_RES_REM:  res_r <= div_rem;
      OP_RES_PERM: res_r <= perm_q_r;
      OP_RES_INV:  res_r <= inv_q_r;
      default: ;
    endcase
    if (cmd.op == OP_OUT) out_r <= res_r;
  end

  // Shared remainder unit
  assign div_start = (cmd.op == OP_TW_TEMP) || (cmd.op == OP_FWD_DIV);
  assign div_dvd   = (cmd.op == OP_TW_TEMP) ? tempered : {1'b0, q_r};
  assign div_dsr   = (cmd.op == OP_TW_TEMP) ? left_r : n;

  spl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Status toward the controller
  always_comb begin
    sts.req_inv    = req_r;
    sts.identity   = seed_r[31];
    sts.n_zero     = (n == 11'd0);
    sts.q_lt_n     = (q_r < {20'd0, n});
    sts.need_build = !valid_r || (built_r != seed_r[30:0]);
    sts.idx_last   = (idx_r == TW_N - 10'd1);
    sts.pool_last  = ({1'b0, idx_r} == n - 11'd1);
    sts.ptr_full   = (ptr_r == TW_N);
    sts.left_one   = (left_r == 11'd1);
    sts.div_done   = div_done;
  end

  assign out_result_index = out_r;

endmodule

### src/spl_ctrl.sv
// Controller: sequences the build, the lookups and the output handshake.
module spl_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  spl_pkg::sts_t  sts,
  output spl_pkg::cmd_t  cmd
);
  import spl_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DECIDE   = 5'd1;
  localparam logic [4:0] S_SEED_MUL = 5'd2;
  localparam logic [4:0] S_SEED_ADD = 5'd3;
  localparam logic [4:0] S_POOL     = 5'd4;
  localparam logic [4:0] S_DRAW     = 5'd5;
  localparam logic [4:0] S_RG_A     = 5'd6;
  localparam logic [4:0] S_RG_B     = 5'd7;
  localparam logic [4:0] S_RG_C     = 5'd8;
  localparam logic [4:0] S_RG_D     = 5'd9;
  localparam logic [4:0] S_TW_RD    = 5'd10;
  localparam logic [4:0] S_TW_TEMP  = 5'd11;
  localparam logic [4:0] S_DRAW_DIV = 5'd12;
  localparam logic [4:0] S_SWAP_RD  = 5'd13;
  localparam logic [4:0] S_SWAP_RD2 = 5'd14;
  localparam logic [4:0] S_SWAP_WR  = 5'd15;
  localparam logic [4:0] S_BDONE    = 5'd16;
  localparam logic [4:0] S_QUERY    = 5'd17;
  localparam logic [4:0] S_FDIV     = 5'd18;
  localparam logic [4:0] S_PERM_RES = 5'd19;
  localparam logic [4:0] S_INV_RES  = 5'd20;
  localparam logic [4:0] S_DONE     = 5'd21;

  logic [4:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state and datapath operation
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts.req_inv) begin
          if (sts.n_zero) begin
            cmd.op = OP_RES_ZERO;  state_nxt = S_DONE;
          end else if (sts.identity) begin
            cmd.op = OP_FWD_DIV;   state_nxt = S_FDIV;
          end else if (sts.need_build) begin
            cmd.op = OP_SEED_INIT; state_nxt = S_SEED_MUL;
          end else begin
            state_nxt = S_QUERY;
          end
        end else begin
          if (sts.identity) begin
            cmd.op = OP_RES_QLOW;  state_nxt = S_DONE;
          end else if (!sts.q_lt_n) begin
            cmd.op = OP_RES_ZERO;  state_nxt = S_DONE;
          end else if (sts.need_build) begin
            cmd.op = OP_SEED_INIT; state_nxt = S_SEED_MUL;
          end else begin
            state_nxt = S_QUERY;
          end
        end
      end
      S_SEED_MUL: begin
        cmd.op = OP_SEED_MUL; state_nxt = S_SEED_ADD;
      end
      S_SEED_ADD: begin
        cmd.op    = OP_SEED_ADD;
        state_nxt = sts.idx_last ? S_POOL : S_SEED_MUL;
      end
      S_POOL: begin
        cmd.op = OP_POOL_INIT;
        if (sts.pool_last) state_nxt = S_DRAW;
      end
      S_DRAW: begin
        cmd.op    = OP_DRAW;
        state_nxt = sts.ptr_full ? S_RG_A : S_TW_RD;
      end
      S_RG_A: begin
        cmd.op = OP_RG_A; state_nxt = S_RG_B;
      end
      S_RG_B: begin
        cmd.op = OP_RG_B; state_nxt = S_RG_C;
      end
      S_RG_C: begin
        cmd.op = OP_RG_C; state_nxt = S_RG_D;
      end
      S_RG_D: begin
        cmd.op    = OP_RG_D;
        state_nxt = sts.idx_last ? S_TW_RD : S_RG_A;
      end
      S_TW_RD: begin
        cmd.op = OP_TW_RD; state_nxt = S_TW_TEMP;
      end
      S_TW_TEMP: begin
        cmd.op = OP_TW_TEMP; state_nxt = S_DRAW_DIV;
      end
      S_DRAW_DIV: begin
        if (sts.div_done) state_nxt = S_SWAP_RD;
      end
      S_SWAP_RD: begin
        cmd.op = OP_SWAP_RD; state_nxt = S_SWAP_RD2;
      end
      S_SWAP_RD2: begin
        cmd.op = OP_SWAP_RD2; state_nxt = S_SWAP_WR;
      end
      S_SWAP_WR: begin
        cmd.op    = OP_SWAP_WR;
        state_nxt = sts.left_one ? S_BDONE : S_DRAW;
      end
      S_BDONE: begin
        cmd.op = OP_BUILD_DONE; state_nxt = S_QUERY;
      end
      S_QUERY: begin
        if (sts.req_inv) begin
          cmd.op = OP_INV_RD;  state_nxt = S_INV_RES;
        end else begin
          cmd.op = OP_FWD_DIV; state_nxt = S_FDIV;
        end
      end
      S_FDIV: begin
        if (sts.div_done) begin
          if (sts.identity) begin
            cmd.op = OP_RES_REM; state_nxt = S_DONE;
          end else begin
            cmd.op = OP_PERM_RD; state_nxt = S_PERM_RES;
          end
        end
      end
      S_PERM_RES: begin
        cmd.op = OP_RES_PERM; state_nxt = S_DONE;
      end
      S_INV_RES: begin
        cmd.op = OP_RES_INV; state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hold the result until the output register frees up
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_build_not_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEED_MUL) |-> !sts.identity)
    else $error("table build started under identity seed");
  a_build_clears_need: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BDONE) |=> !sts.need_build)
    else $error("table still stale after build");
  a_draw_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TW_TEMP) |-> !sts.ptr_full)
    else $error("twister word taken past end of block");
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("output raised outside completion state");
`endif

endmodule

### src/seeded_permutation_lookup.sv
// Top level of the seeded permutation lookup.
//
// Requests enter on in_valid/in_ready with in_req_type (0 forward: position
// to item, 1 inverse: item to position) and in_query_value; one result per
// request leaves on out_valid/out_ready as out_result_index.
// One request is worked at a time. With a valid table a forward lookup
// passes through a 32-step bit-serial remainder unit, then a table read, and
// an inverse lookup through a table read alone; identity forward lookups use
// the remainder unit only, and the rest of identity, zero-count and
// out-of-range requests go straight to the result.
// When the table is stale (count written, or seed changed) the request first
// rebuilds it: the twister is seeded, the pool is filled, each twister block
// of 624 words is regenerated as needed, and each item is drawn, reduced
// modulo the items left in the shared remainder unit and swapped into place,
// all bound by the twister memory and the shared remainder unit.
// Configuration (cfg_we, cfg_index, cfg_wdata) is written while idle by the user; the block does not enforce it.
// Reset clears the seed to -1 (identity), the count to 0 and the table's
// valid flag. A stalled receiver holds the result in the output register;
// the next request is accepted meanwhile, and its result waits behind it.
module seeded_permutation_lookup (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [30:0] in_query_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_result_index
);
  import spl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  spl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  spl_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_req_type      (in_req_type),
    .in_query_value   (in_query_value),
    .cmd              (cmd),
    .sts              (sts),
    .out_result_index (out_result_index)
  );

endmodule

### dv/spl_checker.sv
// Checker for the seeded permutation lookup: snoops config, predicts and compares results.
module spl_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_req_type,
  input  logic [30:0] in_query_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [9:0]  out_result_index,
  output int          fail_count,
  output int          pending
);
  import spl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow registers and predictor state
  logic [31:0]      seed_shadow;
  logic [10:0]      count_shadow;
  logic [31:0]      twister[624];
  int unsigned      twister_pos;
  logic [IDX_W-1:0] order_table[MAX_ITEMS];
  logic [IDX_W-1:0] pool[MAX_ITEMS];
  bit               order_ok;
  logic [30:0]      order_seed;
  logic [9:0]       expected_index_q[$];

  function automatic int unsigned active_count();
    return (count_shadow > 11'(MAX_ITEMS)) ? MAX_ITEMS : 32'(count_shadow);
  endfunction

  // Append one prediction at the tail
  function automatic void queue_expected(logic [9:0] value);
    expected_index_q.insert(expected_index_q.size(), value);
  endfunction

  // Advance the generator and temper one word
  function automatic logic [31:0] twister_draw();
    logic [31:0] y;
    logic [31:0] v;
    if (twister_pos >= 624) begin
      for (int i = 0; i < 624; i++) begin
        y = (twister[i] & 32'h80000000) | (twister[(i + 1) % 624] & 32'h7FFFFFFF);
        v = twister[(i + 397) % 624] ^ (y >> 1);
        if (y[0]) v = v ^ TW_MATRIX;
        twister[i] = v;
      end
      twister_pos = 0;
    end
    y = twister[twister_pos];
    twister_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9D2C5680);
    y = y ^ ((y << 15) & 32'hEFC60000);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // Rebuild the shuffled order when stale
  function automatic void refresh_order();
    int unsigned n;
    int unsigned left;
    logic [31:0] r;
    logic [31:0] p;
    n = active_count();
    if (order_ok && order_seed == seed_shadow[30:0]) return;
    twister[0] = seed_shadow;
    for (int i = 1; i < 624; i++) begin
      p = twister[i-1];
      twister[i] = TW_MULT * (p ^ (p >> 30)) + 32'(i);
    end
    twister_pos = 624;
    for (int i = 0; i < n; i++) pool[i] = IDX_W'(i);
    left = n;
    while (left > 0) begin
      r = twister_draw() % left;
      order_table[n - left] = pool[r];
      pool[r] = pool[left - 1];
      left--;
    end
    order_seed = seed_shadow[30:0];
    order_ok = (n > 0);
  endfunction

  function automatic logic [9:0] lookup_index(logic inverse, logic [30:0] q);
    int unsigned n;
    logic [31:0] res;
    n = active_count();
    res = '0;
    if (!inverse) begin
      if (n > 0) begin
        if (seed_shadow[31]) res = {1'b0, q} % n;
        else begin
          refresh_order();
          res = {22'd0, order_table[{1'b0, q} % n]};
        end
      end
    end else if (seed_shadow[31]) begin
      res = {1'b0, q};
    end else if (q < n) begin
      refresh_order();
      for (int i = 0; i < n; i++) begin
        if (order_table[i] == q[9:0]) begin
          res = 32'(i);
          break;
        end
      end
    end
    return res[9:0];
  endfunction

  // Snoop config, queue predictions, compare results
  always @(posedge clk) begin
    if (!rst_n) begin
      seed_shadow = 32'hFFFFFFFF;
      count_shadow = '0;
      order_ok = 1'b0;
      order_seed = '0;
      twister_pos = 0;
      expected_index_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SEED) seed_shadow = cfg_wdata;
        else if (cfg_index == CFG_COUNT) begin
          count_shadow = cfg_wdata[10:0];
          order_ok = 1'b0;
        end
      end
      if (in_valid && in_ready)
        queue_expected(lookup_index(in_req_type, in_query_value));
      if (out_valid && out_ready) begin
        if (expected_index_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %0d", $time,
                   out_result_index);
          fail_count <= fail_count + 1;
        end else begin
          if (expected_index_q[0] !== out_result_index) begin
            $display("%0t: result_index mismatch: expected %0d, actual %0d", $time,
                     expected_index_q[0], out_result_index);
            fail_count <= fail_count + 1;
          end
          void'(expected_index_q.pop_front());
        end
      end
      pending <= expected_index_q.size();
    end
  end
endmodule

### dv/tb_seeded_permutation_lookup.sv
// Testbench top for the seeded permutation lookup: stimulus, flow control and verdict.
module tb_seeded_permutation_lookup;
  import spl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 80;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        in_req_type;
  logic [30:0] in_query_value;
  logic        out_valid;
  logic        out_ready;
  logic [9:0]  out_result_index;
  int          fail_count;
  int          pending;
  int          cycles;
  int          requests_sent;
  int          configs_done;
  bit          quiet;
  logic [10:0] cur_count;

  seeded_permutation_lookup dut (.*);

  spl_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver stalls in random bursts
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  // Write one register; call at a falling edge
  task automatic write_reg(logic [0:0] idx, logic [31:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    if (idx == CFG_COUNT) cur_count = data[10:0];
    @(negedge clk);
    cfg_we = 1'b0;
    configs_done++;
  endtask

  // Send one request and hold it until accepted; call at a falling edge
  task automatic send_request(logic inverse, logic [30:0] q);
    if (!quiet && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 15)) @(negedge clk);
    in_valid = 1'b1;
    in_req_type = inverse;
    in_query_value = q;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
    requests_sent++;
  endtask

  // Drain all results, then let the block go idle
  task automatic drain();
    while (pending != 0 || in_valid) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Random query shaped toward in-range values
  task automatic random_request();
    logic [30:0] q;
    int unsigned n;
    int sel;
    n = (cur_count > 11'(MAX_ITEMS)) ? MAX_ITEMS : 32'(cur_count);
    sel = $urandom_range(0, 9);
    if (sel < 6 && n > 0) q = 31'($urandom_range(0, n - 1));
    else if (sel < 8) q = 31'($urandom);
    else if (sel == 8) q = 31'h7FFFFFFF;
    else q = 31'($urandom_range(0, 2047));
    send_request(1'($urandom_range(0, 1)), q);
  endtask

  initial begin
    logic [31:0] seed;
    logic [10:0] cnt;
    int phases;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_req_type = 1'b0;
    in_query_value = '0;
    quiet = 1'b0;
    cur_count = '0;
    requests_sent = 0;
    configs_done = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset config: identity with zero count
    send_request(1'b0, 31'd0);
    send_request(1'b1, 31'd5);
    send_request(1'b1, 31'h7FFFFFFF);
    drain();

    // Identity with a small count
    write_reg(CFG_COUNT, 32'd10);
    send_request(1'b0, 31'd12345);
    send_request(1'b0, 31'h7FFFFFFF);
    send_request(1'b1, 31'd1500);
    drain();

    // Shuffled, small count: lookups, out of range item, widest query
    write_reg(CFG_SEED, 32'd5489);
    send_request(1'b0, 31'd0);
    send_request(1'b0, 31'd9);
    send_request(1'b0, 31'h7FFFFFFF);
    send_request(1'b1, 31'd3);
    send_request(1'b1, 31'd10);
    send_request(1'b1, 31'h7FFFFFFF);
    drain();

    // Same seed rewritten: table stays valid
    write_reg(CFG_SEED, 32'd5489);
    send_request(1'b1, 31'd7);
    drain();

    // Zero count while shuffled
    write_reg(CFG_COUNT, 32'd0);
    send_request(1'b0, 31'd77);
    send_request(1'b1, 31'd0);
    drain();

    // Count above capacity saturates; largest seed
    write_reg(CFG_SEED, 32'h7FFFFFFF);
    write_reg(CFG_COUNT, 32'd2047);
    send_request(1'b0, 31'd1023);
    send_request(1'b1, 31'd1023);
    send_request(1'b1, 31'd1024);
    send_request(1'b0, 31'h55555555);
    drain();

    // Most negative seed: identity again
    write_reg(CFG_SEED, 32'h80000000);
    send_request(1'b0, 31'd4000);
    send_request(1'b1, 31'd2047);
    drain();

    // Random phases, each with a fresh seed and all but one with a fresh count
    for (phases = 0; phases < 11; phases++) begin
      if (phases == 10) quiet = 1'b1;
      case ($urandom_range(0, 5))
        0: seed = 32'd0;
        1: seed = $urandom | 32'h80000000;
        default: seed = $urandom & 32'h7FFFFFFF;
      endcase
      if (phases == 4) cnt = 11'd1024;
      else if (phases == 7) cnt = 11'd1;
      else cnt = 11'($urandom_range(1, 64));
      write_reg(CFG_SEED, seed);
      if (phases != 2) write_reg(CFG_COUNT, {21'd0, cnt});
      repeat (25) random_request();
      drain();
    end

    drain();
    $display("Covered %0d requests over %0d register writes, identity and shuffled",
             requests_sent, configs_done);
    $display("tables, counts from 0 to saturation, in-range and out-of-range queries");
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
